>>> design/ssd_pkg.sv
package ssd_pkg;

  localparam int unsigned NUM_W     = 16;
  localparam int unsigned DIG_CNT_W = 3;
  localparam int unsigned SEG_W     = 8;
  localparam int unsigned BIT_CNT_W = 3;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned QUOT_W    = 13;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [DIG_CNT_W-1:0] MAX_DIGITS        = 3'd5;
  localparam logic [DIG_CNT_W-1:0] DIGIT_COUNT_RESET = 3'd4;
  localparam logic                 COMMON_ANODE_RESET = 1'b1;

  // floor(n / 10) == (n * 52429) >> 19 for every 16-bit n
  localparam logic [NUM_W-1:0] RECIP_10    = 16'd52429;
  localparam int unsigned      RECIP_SHIFT = 19;

  typedef enum logic [0:0] {
    REG_DIGIT_COUNT  = 1'b0,
    REG_COMMON_ANODE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEG,
    ST_SHIFT,
    ST_LATCH
  } state_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit,
                                                 input logic            anode);
    logic [SEG_W-1:0] code;
    begin
      unique case (digit)
        4'd0:    code = 8'h3F;
        4'd1:    code = 8'h06;
        4'd2:    code = 8'h5B;
        4'd3:    code = 8'h4F;
        4'd4:    code = 8'h66;
        4'd5:    code = 8'h6D;
        4'd6:    code = 8'h7D;
        4'd7:    code = 8'h07;
        4'd8:    code = 8'h7F;
        4'd9:    code = 8'h6F;
        default: code = 8'h00;
      endcase
      // common-anode codes are the cathode codes inverted
      seg_code = anode ? ~code : code;
    end
  endfunction

endpackage

>>> design/ssd_if.sv
interface ssd_num_if;
  logic                      valid;
  logic                      ready;
  logic [ssd_pkg::NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface ssd_res_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch_strobe;
  logic last;

  modport source (output valid, output serial_bit, output latch_strobe, output last,
                  input ready);
  modport sink   (input valid, input serial_bit, input latch_strobe, input last,
                  output ready);
endinterface

>>> design/seven_segment_serial_display_driver_top.sv
// an accepted number runs the divide and segment states before its first bit word
// per digit: divide and segment states, then 8 bit words, one per cycle if not stalled
// a new number is accepted only once the latch word of the last one has been taken
// one reciprocal multiplier is shared by all digits, which are worked one at a time
// reset: digit_count 4, common_anode 1, sequencer idle, no word pending
module seven_segment_serial_display_driver_top (
  input  logic                        clk,
  input  logic                        rst,
  // apb config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssd_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssd_pkg::DATA_W-1:0]  pwdata,
  output logic [ssd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // streams
  ssd_num_if.sink                     num_ch,
  ssd_res_if.source                   res_ch
);
  import ssd_pkg::*;

  // config registers
  logic [DIG_CNT_W-1:0] digit_count;
  logic                 common_anode;
  reg_idx_t             reg_idx;
  logic                 cfg_wr;

  // sequencer and datapath
  state_t               state;
  state_t               state_next;
  logic [NUM_W-1:0]     num;         // value still to be split into digits
  logic [QUOT_W-1:0]    quot;        // num / 10 from the multiplier
  logic [SEG_W-1:0]     seg;         // segment byte being shifted, msb at top
  logic [BIT_CNT_W-1:0] bit_left;    // bits left in seg after the current one
  logic [DIG_CNT_W-1:0] dig_left;    // digits left including the current one

  logic [PROD_W-1:0]    prod;
  logic [NUM_W-1:0]     quot_x10;
  logic [NUM_W-1:0]     rem_full;
  logic [DIGIT_W-1:0]   digit;
  logic [DIG_CNT_W-1:0] count_sat;
  logic                 num_take;
  logic                 res_take;

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count  <= DIGIT_COUNT_RESET;
      common_anode <= COMMON_ANODE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DIGIT_COUNT:  digit_count  <= pwdata[DIG_CNT_W-1:0];
        REG_COMMON_ANODE: common_anode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIGIT_COUNT:  prdata = {{(DATA_W-DIG_CNT_W){1'b0}}, digit_count};
      REG_COMMON_ANODE: prdata = {{(DATA_W-1){1'b0}}, common_anode};
      default:          prdata = '0;
    endcase
  end

  // ---------------- shared divide-by-10 unit ----------------
  // reciprocal multiply gives the quotient, shift-add times ten gives the remainder
  assign prod     = {{(PROD_W-NUM_W){1'b0}}, num} * {{(PROD_W-NUM_W){1'b0}}, RECIP_10};
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = num - quot_x10;
  assign digit    = rem_full[DIGIT_W-1:0];

  // counts above the display size saturate
  assign count_sat = (digit_count > MAX_DIGITS) ? MAX_DIGITS : digit_count;

  assign num_take = num_ch.valid && num_ch.ready;
  assign res_take = res_ch.valid && res_ch.ready;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (num_ch.valid) begin
                  state_next = (count_sat == '0) ? ST_LATCH : ST_DIV;
                end
      ST_DIV:   state_next = ST_SEG;
      ST_SEG:   state_next = ST_SHIFT;
      ST_SHIFT: if (res_ch.ready && bit_left == '0) begin
                  // last bit of this digit: next digit or the latch pulse
                  state_next = (dig_left == DIG_CNT_W'(1)) ? ST_LATCH : ST_DIV;
                end
      ST_LATCH: if (res_ch.ready) begin
                  state_next = ST_IDLE;
                end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- outputs ----------------
  always_comb begin
    num_ch.ready        = 1'b0;
    res_ch.valid        = 1'b0;
    res_ch.serial_bit   = 1'b0;
    res_ch.latch_strobe = 1'b0;
    res_ch.last         = 1'b0;
    unique case (state)
      ST_IDLE:  num_ch.ready = 1'b1;
      ST_SHIFT: begin
        res_ch.valid      = 1'b1;
        res_ch.serial_bit = seg[SEG_W-1];
      end
      ST_LATCH: begin
        res_ch.valid        = 1'b1;
        res_ch.latch_strobe = 1'b1;
        res_ch.last         = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (num_take) begin
        num      <= num_ch.number;
        dig_left <= count_sat;
      end
      ST_DIV: quot <= prod[RECIP_SHIFT +: QUOT_W];
      ST_SEG: begin
        seg      <= seg_code(digit, common_anode);
        num      <= {{(NUM_W-QUOT_W){1'b0}}, quot};
        bit_left <= BIT_CNT_W'(SEG_W - 1);
      end
      ST_SHIFT: if (res_take) begin
        seg      <= {seg[SEG_W-2:0], 1'b0};
        bit_left <= bit_left - BIT_CNT_W'(1);
        if (bit_left == '0) begin
          dig_left <= dig_left - DIG_CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // never accepting a number while a word is still offered
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    num_ch.ready |-> !res_ch.valid)
    else $error("input ready while result pending");

  // the closing word is the latch pulse with a quiet data line
  a_last_latch: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.last) |-> (res_ch.latch_strobe && !res_ch.serial_bit))
    else $error("last word is not a clean latch strobe");

  // after the latch pulse is taken the block is free again
  a_free_after: assert property (@(posedge clk) disable iff (rst)
    (res_take && res_ch.last) |=> num_ch.ready)
    else $error("not ready after run finished");

  // shifting never runs with no digit left
  a_dig_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (dig_left != '0 && dig_left <= MAX_DIGITS))
    else $error("digit counter out of range");
`endif

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ssd_pkg::*;

  // one shifted word: data bit or latch pulse
  typedef struct packed {
    logic serial_bit;
    logic latch_strobe;
    logic last;
  } shift_word_t;

  // segment tables, index is the decimal digit
  localparam logic [SEG_W-1:0] ANODE_CODES [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  localparam logic [SEG_W-1:0] CATHODE_CODES [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // receiver hold-off used to back the block up into its input
  localparam int LONG_HOLD = 300;

  logic clk;
  logic rst;

  // apb config port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ssd_num_if num_ch ();
  ssd_res_if res_ch ();

  seven_segment_serial_display_driver_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .num_ch  (num_ch),
    .res_ch  (res_ch)
  );

  // numbers waiting to be offered, and words the block still owes us
  logic [NUM_W-1:0] numbers_due[$];
  shift_word_t      seg_bits_due[$];

  // shadow copy of the two registers
  logic [DIG_CNT_W-1:0] cfg_digits;
  logic                 cfg_anode;

  int  numbers_queued;
  int  numbers_taken;
  int  words_seen;
  int  reg_writes;
  int  err_count;
  bit  idle_on;
  int  hold_orders;
  int  hold_seen;
  int  src_gap;
  int  sink_stall;

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // every input known from time zero, reset held at start and released on a clock edge
  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    num_ch.valid   = 1'b0;
    num_ch.number  = '0;
    res_ch.ready   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("seven_segment_serial_display_driver_top: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  // expected words for one number under the current register values:
  // digits go out least significant first, each segment byte msb first,
  // then a single latch pulse that also carries last
  function automatic void queue_segment_bits(input logic [NUM_W-1:0] value);
    int unsigned      rest;
    int unsigned      shown;
    logic [SEG_W-1:0] code;
    rest  = value;
    // counts above the digit chain length saturate; zero sends only the latch
    shown = (cfg_digits > MAX_DIGITS) ? MAX_DIGITS : cfg_digits;
    for (int d = 0; d < shown; d++) begin
      code = cfg_anode ? ANODE_CODES[rest % 10] : CATHODE_CODES[rest % 10];
      rest = rest / 10;
      for (int b = SEG_W - 1; b >= 0; b--) begin
        seg_bits_due.push_back('{serial_bit: code[b], latch_strobe: 1'b0, last: 1'b0});
      end
    end
    seg_bits_due.push_back('{serial_bit: 1'b0, latch_strobe: 1'b1, last: 1'b1});
  endfunction

  // number driver: holds valid until taken, inserts random gaps while idle_on is set
  always @(posedge clk) begin : drive_numbers
    logic offer;
    if (rst) begin
      num_ch.valid  <= 1'b0;
      num_ch.number <= '0;
      src_gap = 0;
    end else begin
      // predict at the edge the word is taken, registers are stable by then
      if (num_ch.valid && num_ch.ready) begin
        queue_segment_bits(num_ch.number);
        numbers_taken++;
      end
      if (!num_ch.valid || num_ch.ready) begin
        offer = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (numbers_due.size() > 0) begin
          if (idle_on && $urandom_range(0, 3) == 0) begin
            src_gap = $urandom_range(0, 10);
          end else begin
            offer = 1'b1;
            num_ch.number <= numbers_due.pop_front();
          end
        end
        num_ch.valid <= offer;
      end
    end
  end

  // result monitor and ready generator
  always @(posedge clk) begin : check_words
    shift_word_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      sink_stall = 0;
      hold_seen  = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        words_seen++;
        if (seg_bits_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word: bit %0b latch %0b last %0b",
                                    res_ch.serial_bit, res_ch.latch_strobe, res_ch.last));
        end else begin
          want = seg_bits_due.pop_front();
          if (res_ch.serial_bit !== want.serial_bit)
            report_mismatch($sformatf("serial_bit got %0b want %0b (word %0d)",
                                      res_ch.serial_bit, want.serial_bit, words_seen));
          if (res_ch.latch_strobe !== want.latch_strobe)
            report_mismatch($sformatf("latch_strobe got %0b want %0b (word %0d)",
                                      res_ch.latch_strobe, want.latch_strobe, words_seen));
          if (res_ch.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b (word %0d)",
                                      res_ch.last, want.last, words_seen));
        end
      end
      // a new long hold-off request replaces any short stall in progress
      if (hold_seen != hold_orders) begin
        hold_seen  = hold_orders;
        sink_stall = LONG_HOLD;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        sink_stall = $urandom_range(0, 10);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [NUM_W-1:0] value);
    numbers_due.push_back(value);
    numbers_queued++;
  endtask

  // wait at the falling edge until every number is taken and every word has come
  task automatic drain();
    do @(negedge clk);
    while (numbers_taken != numbers_queued || seg_bits_due.size() != 0);
  endtask

  // apb write: setup cycle, then access cycle; the register takes the value
  // at the edge where psel, penable, pwrite and pready are all high
  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DIGIT_COUNT) cfg_digits = val[DIG_CNT_W-1:0];
    else cfg_anode = val[0];
    reg_writes++;
  endtask

  // only called once the block is drained
  task automatic set_config(input int digits, input bit anode);
    repeat (5) @(negedge clk);
    apb_write(REG_DIGIT_COUNT, DATA_W'(digits));
    apb_write(REG_COMMON_ANODE, DATA_W'(anode));
  endtask

  // random number, weighted toward short values and digit boundaries
  function automatic logic [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] edges [10] = '{0, 9, 10, 99, 100, 999, 1000, 9999, 10000, 65535};
    case ($urandom_range(0, 3))
      0:       return NUM_W'($urandom_range(0, 65535));
      1:       return NUM_W'($urandom_range(0, 99));
      2:       return NUM_W'($urandom_range(0, 9999));
      default: return edges[$urandom_range(0, 9)];
    endcase
  endfunction

  initial begin : run_phases
    cfg_digits     = DIGIT_COUNT_RESET;
    cfg_anode      = COMMON_ANODE_RESET;
    numbers_queued = 0;
    numbers_taken  = 0;
    words_seen     = 0;
    reg_writes     = 0;
    err_count      = 0;
    hold_orders    = 0;
    idle_on        = 1'b1;

    do @(negedge clk);
    while (rst);

    // reset values: four digits, common-anode codes; all ten digits, all-zero and
    // all-ones numbers, and a five-digit value with its top digit dropped
    send(0);
    send(65535);
    send(1234);
    send(5678);
    send(9);
    send(10000);
    drain();

    // widest chain with cathode codes, upper digits padded with zero
    set_config(5, 1'b0);
    send(0);
    send(65535);
    send(12345);
    send(6789);
    send(9);
    send(10);
    drain();

    // zero digit count: latch pulse alone
    set_config(0, 1'b1);
    send(65535);
    send(0);
    send(42);
    drain();

    // counts of 6 and 7 saturate at the chain length
    set_config(7, 1'b0);
    send(54321);
    send(65535);
    drain();
    set_config(6, 1'b1);
    send(9876);
    drain();

    // single digit
    set_config(1, 1'b0);
    send(0);
    send(5);
    send(65535);
    drain();

    // random phases, each with fresh register values and idling on both sides
    for (int p = 0; p < 5; p++) begin
      set_config($urandom_range(0, 7), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 12; i++) send(pick_number());
      drain();
    end

    // back-pressure: receiver holds off for a long stretch while numbers keep
    // coming without gaps, so the block stalls its input; then the sender
    // pauses until everything has drained
    idle_on = 1'b0;
    set_config(5, 1'b1);
    hold_orders++;
    for (int i = 0; i < 12; i++) send(pick_number());
    drain();

    // closing stretch with no idling at all
    set_config($urandom_range(1, 5), 1'($urandom_range(0, 1)));
    for (int i = 0; i < 14; i++) send(pick_number());
    drain();

    // room for any stray word to show up
    repeat (60) @(negedge clk);

    $display("covered %0d numbers and %0d shift/latch words over %0d register writes,",
             numbers_taken, words_seen, reg_writes);
    $display("digit counts 0 to 7, both segment tables, random stalls and a long hold-off");
    if (err_count == 0) begin
      $display("seven_segment_serial_display_driver_top: match");
    end else begin
      $display("seven_segment_serial_display_driver_top: mismatch");
    end
    $finish;
  end

endmodule

>>> seven_segment_serial_display_driver_top.f
design/ssd_pkg.sv
design/ssd_if.sv
design/seven_segment_serial_display_driver_top.sv
sim/testbench.sv
